// ----- rtl/text_console_cursor_engine_top_assert.svh -----
// assertion macros for the text console cursor engine
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cursor engine: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cursor engine: next-cycle check failed");

`endif

// ----- rtl/tcce_pkg.sv -----
// shared constants and types of the text console cursor engine
`default_nettype none

package tcce_pkg;

    // request kinds
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // result commands
    localparam logic [1:0] CMD_REPORT = 2'd0;
    localparam logic [1:0] CMD_DRAW   = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // tab stops every four columns
    localparam int TAB_STEP     = 4;
    localparam int TAB_LOW_MASK = 3;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR = 3'd4;

    // configuration reset values
    localparam logic [7:0]  COLUMNS_RESET  = 8'd80;
    localparam logic [7:0]  ROWS_RESET     = 8'd25;
    localparam logic [23:0] FG_COLOR_RESET = 24'hFFFFFF;
    localparam logic [23:0] BG_COLOR_RESET = 24'h000000;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 88;

    // outcome of one request as worked out by the core
    typedef struct packed {
        logic [1:0] first_cmd;
        logic [7:0] glyph;
        logic [7:0] draw_col;
        logic [7:0] draw_row;
        logic       two;
        logic [1:0] second_cmd;
    } tcce_plan_t;

    // one result as held in the output register
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  glyph_code;
        logic [7:0]  draw_col;
        logic [7:0]  draw_row;
        logic [23:0] draw_fg;
        logic [23:0] draw_bg;
        logic [7:0]  cursor_col_now;
        logic [7:0]  cursor_row_now;
        logic        last;
    } tcce_result_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_cursor_engine_top.sv -----
// text console cursor engine: input register, core logic, two-slot result register
// an item passes the input register and then the output register on its way to m_tvalid
// throughput: one item per cycle when it gives one result and m_tready is high; an item with
// two results leaves its second in a pending slot, which holds off the next item
// reset (aresetn, synchronous, active low) empties both stages, zeroes the cursor
// and loads the configuration defaults
`default_nettype none

module text_console_cursor_engine_top #(
    parameter int COORD_BITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic [tcce_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // request stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // char_code [7:0], new_col [15:8], new_row [23:16]
    input  wire logic [tcce_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type [1:0]
    input  wire logic [1:0]                          s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // glyph_code [7:0], draw_col [15:8], draw_row [23:16], draw_fg [47:24],
    // draw_bg [71:48], cursor_col_now [79:72], cursor_row_now [87:80]
    output logic      [tcce_pkg::M_TDATA_W-1:0]      m_tdata,
    // cmd [1:0]
    output logic      [1:0]                          m_tuser,
    output logic                                     m_tlast
);

    `include "text_console_cursor_engine_top_assert.svh"

    logic                    enabled_reg;
    logic [7:0]              columns_reg;
    logic [7:0]              rows_reg;
    logic [23:0]             fg_color_reg;
    logic [23:0]             bg_color_reg;

    logic [COORD_BITS-1:0]   cursor_col_reg;
    logic [COORD_BITS-1:0]   cursor_row_reg;
    logic [COORD_BITS-1:0]   cursor_col_next;
    logic [COORD_BITS-1:0]   cursor_row_next;

    logic                    in_valid_reg;
    logic [1:0]              in_req_reg;
    logic [7:0]              in_char_reg;
    logic [7:0]              in_col_reg;
    logic [7:0]              in_row_reg;

    tcce_pkg::tcce_result_t  out_reg;
    tcce_pkg::tcce_result_t  first_next;
    logic                    out_valid_reg;
    logic                    pend_valid_reg;
    logic [1:0]              pend_cmd_reg;

    tcce_pkg::tcce_plan_t    plan;
    logic                    out_free;
    logic                    consume;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg  <= 1'b0;
            columns_reg  <= tcce_pkg::COLUMNS_RESET;
            rows_reg     <= tcce_pkg::ROWS_RESET;
            fg_color_reg <= tcce_pkg::FG_COLOR_RESET;
            bg_color_reg <= tcce_pkg::BG_COLOR_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tcce_pkg::REG_ENABLED:  enabled_reg  <= cfg_wdata[0];
                tcce_pkg::REG_COLUMNS:  columns_reg  <= cfg_wdata[7:0];
                tcce_pkg::REG_ROWS:     rows_reg     <= cfg_wdata[7:0];
                tcce_pkg::REG_FG_COLOR: fg_color_reg <= cfg_wdata;
                tcce_pkg::REG_BG_COLOR: bg_color_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // handshake between the stages
    assign out_free = !out_valid_reg || (m_tready && !pend_valid_reg);
    assign consume  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || consume;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= s_tuser;
            in_char_reg <= s_tdata[7:0];
            in_col_reg  <= s_tdata[15:8];
            in_row_reg  <= s_tdata[23:16];
        end
    end

    tcce_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .enabled         (enabled_reg),
        .text_columns    (columns_reg),
        .text_rows       (rows_reg),
        .req_type        (in_req_reg),
        .char_code       (in_char_reg),
        .new_col         (in_col_reg),
        .new_row         (in_row_reg),
        .cursor_col      (cursor_col_reg),
        .cursor_row      (cursor_row_reg),
        .cursor_col_next (cursor_col_next),
        .cursor_row_next (cursor_row_next),
        .plan            (plan)
    );

    // cursor state moves as each item is taken by the core
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end else if (consume) begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

    // first result of the item; draw fields only on a glyph draw
    always_comb begin
        first_next                = '0;
        first_next.cmd            = plan.first_cmd;
        first_next.cursor_col_now = 8'(cursor_col_next);
        first_next.cursor_row_now = 8'(cursor_row_next);
        first_next.last           = !plan.two;
        if (plan.first_cmd == tcce_pkg::CMD_DRAW) begin
            first_next.glyph_code = plan.glyph;
            first_next.draw_col   = plan.draw_col;
            first_next.draw_row   = plan.draw_row;
            first_next.draw_fg    = fg_color_reg;
            first_next.draw_bg    = bg_color_reg;
        end
    end

    // output control: shown result plus a pending second command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (consume) begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= plan.two;
        end else if (m_tvalid && m_tready) begin
            if (pend_valid_reg) begin
                pend_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (consume) begin
            out_reg      <= first_next;
            pend_cmd_reg <= plan.second_cmd;
        end else if (m_tvalid && m_tready && pend_valid_reg) begin
            out_reg.cmd        <= pend_cmd_reg;
            out_reg.glyph_code <= 8'd0;
            out_reg.draw_col   <= 8'd0;
            out_reg.draw_row   <= 8'd0;
            out_reg.draw_fg    <= 24'd0;
            out_reg.draw_bg    <= 24'd0;
            out_reg.last       <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.cmd;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {out_reg.cursor_row_now, out_reg.cursor_col_now,
                       out_reg.draw_bg, out_reg.draw_fg,
                       out_reg.draw_row, out_reg.draw_col, out_reg.glyph_code};

    // a pending second command always sits behind a shown first result
    `TCCE_ASSERT_NOW(a_pend_needs_out, pend_valid_reg, out_valid_reg)

    // a non-final result is always followed by a pending one
    `TCCE_ASSERT_NOW(a_not_last_has_pend, m_tvalid && !m_tlast, pend_valid_reg)

    // taking the first of two results shows the final one next
    `TCCE_ASSERT_NEXT(a_pend_follows, m_tvalid && m_tready && pend_valid_reg,
                      m_tvalid && m_tlast)

    // an item taken by the core is shown in the next cycle
    `TCCE_ASSERT_NEXT(a_consume_shows, consume, m_tvalid)

endmodule

`default_nettype wire

// ----- rtl/tcce_core.sv -----
// request decode and cursor arithmetic of the text console cursor engine
`default_nettype none

module tcce_core #(
    parameter int COORD_BITS = 8
) (
    input  wire logic                  enabled,
    input  wire logic [7:0]            text_columns,
    input  wire logic [7:0]            text_rows,
    input  wire logic [1:0]            req_type,
    input  wire logic [7:0]            char_code,
    input  wire logic [7:0]            new_col,
    input  wire logic [7:0]            new_row,
    input  wire logic [COORD_BITS-1:0] cursor_col,
    input  wire logic [COORD_BITS-1:0] cursor_row,
    output logic      [COORD_BITS-1:0] cursor_col_next,
    output logic      [COORD_BITS-1:0] cursor_row_next,
    output tcce_pkg::tcce_plan_t       plan
);

    // sums carry one extra bit, compares cover the 8-bit geometry too
    localparam int SW = COORD_BITS + 1;
    localparam int CW = (SW > 8) ? SW : 8;

    logic [SW-1:0] col_s;
    logic [SW-1:0] row_s;
    logic [CW-1:0] cols_eff;
    logic [CW-1:0] rows_eff;
    logic          draw;
    logic [7:0]    glyph;
    logic [7:0]    dcol;
    logic [7:0]    drow;
    logic          extra;
    logic [1:0]    extra_cmd;

    // zero geometry behaves as one
    assign cols_eff = (text_columns == 8'd0) ? CW'(1) : CW'(text_columns);
    assign rows_eff = (text_rows == 8'd0) ? CW'(1) : CW'(text_rows);

    // cursor movement and command selection
    always_comb begin
        col_s           = SW'(cursor_col);
        row_s           = SW'(cursor_row);
        draw            = 1'b0;
        glyph           = 8'd0;
        dcol            = 8'd0;
        drow            = 8'd0;
        extra           = 1'b0;
        extra_cmd       = tcce_pkg::CMD_REPORT;
        cursor_col_next = cursor_col;
        cursor_row_next = cursor_row;
        case (req_type)
            tcce_pkg::REQ_SET: begin
                cursor_col_next = COORD_BITS'(new_col);
                cursor_row_next = COORD_BITS'(new_row);
            end
            tcce_pkg::REQ_CLEAR: begin
                if (enabled) begin
                    cursor_col_next = '0;
                    cursor_row_next = '0;
                    extra           = 1'b1;
                    extra_cmd       = tcce_pkg::CMD_CLEAR;
                end
            end
            tcce_pkg::REQ_PUT: begin
                if (enabled) begin
                    case (char_code)
                        tcce_pkg::CH_NEWLINE: begin
                            col_s = '0;
                            row_s = row_s + SW'(1);
                        end
                        tcce_pkg::CH_RETURN: begin
                            col_s = '0;
                        end
                        tcce_pkg::CH_TAB: begin
                            col_s = (col_s + SW'(tcce_pkg::TAB_STEP))
                                    & ~SW'(tcce_pkg::TAB_LOW_MASK);
                            if (CW'(col_s) >= cols_eff) begin
                                col_s = '0;
                                row_s = row_s + SW'(1);
                            end
                        end
                        tcce_pkg::CH_BACKSPACE: begin
                            if (col_s != '0) begin
                                col_s = col_s - SW'(1);
                                draw  = 1'b1;
                                glyph = tcce_pkg::CH_SPACE;
                                dcol  = 8'(col_s);
                                drow  = 8'(row_s);
                            end
                        end
                        default: begin
                            draw  = 1'b1;
                            glyph = char_code;
                            dcol  = 8'(col_s);
                            drow  = 8'(row_s);
                            col_s = col_s + SW'(1);
                        end
                    endcase
                    // wrap at the right edge
                    if (CW'(col_s) >= cols_eff) begin
                        col_s = '0;
                        row_s = row_s + SW'(1);
                    end
                    // scroll past the bottom, a single row clears instead
                    if (CW'(row_s) >= rows_eff) begin
                        extra = 1'b1;
                        if (rows_eff == CW'(1)) begin
                            col_s     = '0;
                            row_s     = '0;
                            extra_cmd = tcce_pkg::CMD_CLEAR;
                        end else begin
                            row_s     = SW'(rows_eff - CW'(1));
                            extra_cmd = tcce_pkg::CMD_SCROLL;
                        end
                    end
                    cursor_col_next = COORD_BITS'(col_s);
                    cursor_row_next = COORD_BITS'(row_s);
                end
            end
            default: begin
            end
        endcase
    end

    // draw goes first, scroll or clear second
    always_comb begin
        plan            = '0;
        plan.glyph      = glyph;
        plan.draw_col   = dcol;
        plan.draw_row   = drow;
        plan.two        = draw & extra;
        plan.second_cmd = extra_cmd;
        if (draw) begin
            plan.first_cmd = tcce_pkg::CMD_DRAW;
        end else if (extra) begin
            plan.first_cmd = extra_cmd;
        end else begin
            plan.first_cmd = tcce_pkg::CMD_REPORT;
        end
    end

endmodule

`default_nettype wire
